[rtl/mvna_pkg.sv]
// shared types, constants and widths of the vertex normal accumulator
package mvna_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int IDX_W        = 12;
    localparam int BASE_W       = 12;
    localparam int COORD_W      = 20;
    localparam int EDGE_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * EDGE_W;
    localparam int CROSS_W      = PROD_W + 1;
    localparam int SUM_W        = 24;
    localparam int NORM_W       = 16;
    localparam int MAG_W        = 31;
    localparam int SQ_W         = 64;
    localparam int LEN_W        = 32;
    localparam int QUO_W        = 15;
    localparam int FRAC_W       = 14;
    localparam int NUM_W        = MAG_W + FRAC_W + 1;
    localparam int ROOT_STEPS   = SQ_W / 2;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef enum logic [1:0] {
        K_LOAD,
        K_TRI,
        K_READ
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]                 operation;
        logic [IDX_W-1:0]           index_a;
        logic [IDX_W-1:0]           index_b;
        logic [IDX_W-1:0]           index_c;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
    } in_word_t;

    typedef struct packed {
        logic signed [NORM_W-1:0]   normal_x;
        logic signed [NORM_W-1:0]   normal_y;
        logic signed [NORM_W-1:0]   normal_z;
        logic                       status;
    } out_word_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic                       oor;
        logic [ADDR_W-1:0]          idx0;
        logic [ADDR_W-1:0]          idx1;
        logic [ADDR_W-1:0]          idx2;
        logic [3*COORD_W-1:0]       vtx;
    } cmd_t;

    typedef struct packed {
        logic                       start;
        logic                       flip;
        logic signed [CROSS_W-1:0]  vx;
        logic signed [CROSS_W-1:0]  vy;
        logic signed [CROSS_W-1:0]  vz;
    } norm_req_t;

    typedef struct packed {
        logic                       done;
        logic                       zero;
        logic signed [NORM_W-1:0]   qx;
        logic signed [NORM_W-1:0]   qy;
        logic signed [NORM_W-1:0]   qz;
    } norm_rsp_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_ROOT,
        N_DINIT,
        N_DSTEP,
        N_DONE
    } norm_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_VREAD,
        B_EDGE,
        B_MUL,
        B_NSTART,
        B_NWAIT,
        B_RMW_RD,
        B_RMW_UPD,
        B_SREAD,
        B_SWAIT,
        B_OUT
    } back_state_t;

endpackage

[rtl/mvna_front.sv]
// front end: index base register, item classification and command queue
module mvna_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  mvna_pkg::in_word_t          s_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mvna_pkg::BASE_W-1:0] cfg_data,
    input  logic                        pop,
    output logic                        head_valid,
    output mvna_pkg::cmd_t              head
);

    logic [mvna_pkg::BASE_W-1:0]  index_base_reg;
    mvna_pkg::cmd_t               fifo_reg [mvna_pkg::FIFO_DEPTH];
    logic [mvna_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mvna_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mvna_pkg::FIFO_AW:0]   count_reg, count_next;

    mvna_pkg::cmd_t               cmd_in;
    logic                         keep;
    logic                         push;
    logic [mvna_pkg::IDX_W:0]     sa, sb, sc;
    logic                         a_ok, ta_ok, tb_ok, tc_ok;
    logic signed [mvna_pkg::COORD_W-1:0] neg_x;

    assign cfg_ready = 1'b1;

    always_comb begin
        sa    = {1'b0, s_data.index_a} + (mvna_pkg::IDX_W+1)'(index_base_reg);
        sb    = {1'b0, s_data.index_b} + (mvna_pkg::IDX_W+1)'(index_base_reg);
        sc    = {1'b0, s_data.index_c} + (mvna_pkg::IDX_W+1)'(index_base_reg);
        a_ok  = 32'(s_data.index_a) < 32'(mvna_pkg::MAX_VERTICES);
        ta_ok = 32'(sa) < 32'(mvna_pkg::MAX_VERTICES);
        tb_ok = 32'(sb) < 32'(mvna_pkg::MAX_VERTICES);
        tc_ok = 32'(sc) < 32'(mvna_pkg::MAX_VERTICES);
        // -x of the most negative code saturates
        if (s_data.coord_x == {1'b1, {(mvna_pkg::COORD_W-1){1'b0}}}) begin
            neg_x = {1'b0, {(mvna_pkg::COORD_W-1){1'b1}}};
        end else begin
            neg_x = -s_data.coord_x;
        end
        cmd_in.kind = mvna_pkg::K_LOAD;
        cmd_in.oor  = 1'b0;
        cmd_in.idx0 = mvna_pkg::ADDR_W'(s_data.index_a);
        cmd_in.idx1 = mvna_pkg::ADDR_W'(s_data.index_b);
        cmd_in.idx2 = mvna_pkg::ADDR_W'(s_data.index_c);
        cmd_in.vtx  = {neg_x, s_data.coord_z, s_data.coord_y};
        keep        = 1'b0;
        case (s_data.operation)
            mvna_pkg::OP_LOAD: begin
                keep = a_ok;
            end
            mvna_pkg::OP_TRI: begin
                cmd_in.kind = mvna_pkg::K_TRI;
                cmd_in.idx0 = mvna_pkg::ADDR_W'(sa);
                cmd_in.idx1 = mvna_pkg::ADDR_W'(sb);
                cmd_in.idx2 = mvna_pkg::ADDR_W'(sc);
                keep        = ta_ok && tb_ok && tc_ok;
            end
            mvna_pkg::OP_READ: begin
                cmd_in.kind = mvna_pkg::K_READ;
                cmd_in.oor  = !a_ok;
                keep        = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready    = count_reg != (mvna_pkg::FIFO_AW+1)'(mvna_pkg::FIFO_DEPTH);
    assign push       = s_valid && s_ready && keep;
    assign head_valid = count_reg != '0;
    assign head       = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_base_reg <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                index_base_reg <= cfg_data;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

[rtl/mvna_norm.sv]
// normalising unit: prescale, sum of squares, bit-serial root and divides
module mvna_norm (
    input  logic                aclk,
    input  logic                aresetn,
    input  mvna_pkg::norm_req_t req,
    output mvna_pkg::norm_rsp_t rsp
);

    mvna_pkg::norm_state_t         state_reg, state_next;
    logic [mvna_pkg::CROSS_W-1:0]  mag_reg [3];
    logic [mvna_pkg::CROSS_W-1:0]  mag_next [3];
    logic                          neg_reg [3];
    logic                          neg_next [3];
    logic signed [mvna_pkg::NORM_W-1:0] q_reg [3];
    logic signed [mvna_pkg::NORM_W-1:0] q_next [3];
    logic [1:0]                    cnt_reg, cnt_next;
    logic [mvna_pkg::SQ_W-1:0]     acc_reg, acc_next;
    logic [mvna_pkg::SQ_W-1:0]     rv_reg, rv_next;
    logic [mvna_pkg::SQ_W-1:0]     root_reg, root_next;
    logic [4:0]                    step_reg, step_next;
    logic [mvna_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [mvna_pkg::LEN_W-1:0]    rem_reg, rem_next;
    logic [mvna_pkg::QUO_W-1:0]    low_reg, low_next;
    logic [mvna_pkg::QUO_W-1:0]    quo_reg, quo_next;
    logic [3:0]                    dstep_reg, dstep_next;
    logic                          zero_reg, zero_next;

    logic [2*mvna_pkg::MAG_W-1:0]  sq_w;
    logic [mvna_pkg::SQ_W-1:0]     bit_w, t_w;
    logic [mvna_pkg::NUM_W-1:0]    num_w;
    logic [mvna_pkg::LEN_W:0]      trial_w;
    logic [mvna_pkg::QUO_W-1:0]    quo_w;
    logic [mvna_pkg::CROSS_W-1:0]  ax, ay, az;

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        rv_next    = rv_reg;
        root_next  = root_reg;
        step_next  = step_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        quo_next   = quo_reg;
        dstep_next = dstep_reg;
        zero_next  = zero_reg;
        ax = req.vx[mvna_pkg::CROSS_W-1] ? mvna_pkg::CROSS_W'(-req.vx)
                                          : mvna_pkg::CROSS_W'(req.vx);
        ay = req.vy[mvna_pkg::CROSS_W-1] ? mvna_pkg::CROSS_W'(-req.vy)
                                          : mvna_pkg::CROSS_W'(req.vy);
        az = req.vz[mvna_pkg::CROSS_W-1] ? mvna_pkg::CROSS_W'(-req.vz)
                                          : mvna_pkg::CROSS_W'(req.vz);
        sq_w    = mag_reg[cnt_reg][mvna_pkg::MAG_W-1:0] *
                  mag_reg[cnt_reg][mvna_pkg::MAG_W-1:0];
        bit_w   = mvna_pkg::SQ_W'(1) << {~step_reg, 1'b0};
        t_w     = root_reg + bit_w;
        num_w   = {1'b0, mag_reg[cnt_reg][mvna_pkg::MAG_W-1:0], {mvna_pkg::FRAC_W{1'b0}}}
                  + mvna_pkg::NUM_W'(len_reg >> 1);
        trial_w = {rem_reg, low_reg[mvna_pkg::QUO_W-1]};
        quo_w   = {quo_reg[mvna_pkg::QUO_W-2:0], trial_w >= {1'b0, len_reg}};
        case (state_reg)
            mvna_pkg::N_IDLE: begin
                if (req.start) begin
                    mag_next[0] = ax;
                    mag_next[1] = ay;
                    mag_next[2] = az;
                    neg_next[0] = req.vx[mvna_pkg::CROSS_W-1] ^ req.flip;
                    neg_next[1] = req.vy[mvna_pkg::CROSS_W-1] ^ req.flip;
                    neg_next[2] = req.vz[mvna_pkg::CROSS_W-1] ^ req.flip;
                    if (ax == '0 && ay == '0 && az == '0) begin
                        zero_next  = 1'b1;
                        q_next[0]  = '0;
                        q_next[1]  = '0;
                        q_next[2]  = '0;
                        state_next = mvna_pkg::N_DONE;
                    end else begin
                        zero_next  = 1'b0;
                        state_next = mvna_pkg::N_SHIFT;
                    end
                end
            end
            mvna_pkg::N_SHIFT: begin
                // one bit a cycle until every magnitude fits the squarer
                if ((|mag_reg[0][mvna_pkg::CROSS_W-1:mvna_pkg::MAG_W]) ||
                    (|mag_reg[1][mvna_pkg::CROSS_W-1:mvna_pkg::MAG_W]) ||
                    (|mag_reg[2][mvna_pkg::CROSS_W-1:mvna_pkg::MAG_W])) begin
                    mag_next[0] = mag_reg[0] >> 1;
                    mag_next[1] = mag_reg[1] >> 1;
                    mag_next[2] = mag_reg[2] >> 1;
                end else begin
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = mvna_pkg::N_SQ;
                end
            end
            mvna_pkg::N_SQ: begin
                acc_next = acc_reg + mvna_pkg::SQ_W'(sq_w);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd2) begin
                    rv_next    = acc_reg + mvna_pkg::SQ_W'(sq_w);
                    root_next  = '0;
                    step_next  = '0;
                    state_next = mvna_pkg::N_ROOT;
                end
            end
            mvna_pkg::N_ROOT: begin
                if (rv_reg >= t_w) begin
                    rv_next   = rv_reg - t_w;
                    root_next = (root_reg >> 1) + bit_w;
                end else begin
                    root_next = root_reg >> 1;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 5'(mvna_pkg::ROOT_STEPS - 1)) begin
                    len_next   = mvna_pkg::LEN_W'(root_next);
                    cnt_next   = '0;
                    state_next = mvna_pkg::N_DINIT;
                end
            end
            mvna_pkg::N_DINIT: begin
                // quotient stays below 2^15, so the top bits start as remainder
                rem_next   = mvna_pkg::LEN_W'(num_w[mvna_pkg::NUM_W-1:mvna_pkg::QUO_W]);
                low_next   = num_w[mvna_pkg::QUO_W-1:0];
                quo_next   = '0;
                dstep_next = '0;
                state_next = mvna_pkg::N_DSTEP;
            end
            mvna_pkg::N_DSTEP: begin
                if (trial_w >= {1'b0, len_reg}) begin
                    rem_next = mvna_pkg::LEN_W'(trial_w - {1'b0, len_reg});
                end else begin
                    rem_next = trial_w[mvna_pkg::LEN_W-1:0];
                end
                low_next   = low_reg << 1;
                quo_next   = quo_w;
                dstep_next = dstep_reg + 1'b1;
                if (dstep_reg == 4'(mvna_pkg::QUO_W - 1)) begin
                    q_next[cnt_reg] = neg_reg[cnt_reg] ? -mvna_pkg::NORM_W'(quo_w)
                                                       : mvna_pkg::NORM_W'(quo_w);
                    if (cnt_reg == 2'd2) begin
                        state_next = mvna_pkg::N_DONE;
                    end else begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = mvna_pkg::N_DINIT;
                    end
                end
            end
            mvna_pkg::N_DONE: begin
                state_next = mvna_pkg::N_IDLE;
            end
            default: begin
                state_next = mvna_pkg::N_IDLE;
            end
        endcase
    end

    assign rsp.done = state_reg == mvna_pkg::N_DONE;
    assign rsp.zero = zero_reg;
    assign rsp.qx   = q_reg[0];
    assign rsp.qy   = q_reg[1];
    assign rsp.qz   = q_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mvna_pkg::N_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        rv_reg    <= rv_next;
        root_reg  <= root_next;
        step_reg  <= step_next;
        len_reg   <= len_next;
        rem_reg   <= rem_next;
        low_reg   <= low_next;
        quo_reg   <= quo_next;
        dstep_reg <= dstep_next;
        zero_reg  <= zero_next;
    end

endmodule

[rtl/mvna_back.sv]
// back end: vertex and sum memories, cross product, accumulate and read-out
module mvna_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  mvna_pkg::cmd_t      head,
    output logic                pop,
    output mvna_pkg::norm_req_t nreq,
    input  mvna_pkg::norm_rsp_t nrsp,
    output logic                m_valid,
    input  logic                m_ready,
    output mvna_pkg::out_word_t m_data
);

    localparam int VW = 3 * mvna_pkg::COORD_W;
    localparam int SW = 3 * mvna_pkg::SUM_W;
    localparam int CW = mvna_pkg::COORD_W;
    localparam int UW = mvna_pkg::SUM_W;

    logic [VW-1:0] vmem [mvna_pkg::MAX_VERTICES];
    logic [SW-1:0] smem [mvna_pkg::MAX_VERTICES];
    logic [VW-1:0] vrd_reg;
    logic [SW-1:0] srd_reg;

    mvna_pkg::back_state_t state_reg, state_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [2:0]    mcnt_reg, mcnt_next;
    logic [VW-1:0] vtx_reg [3];
    logic [VW-1:0] vtx_next [3];
    logic signed [mvna_pkg::EDGE_W-1:0]  e1_reg [3];
    logic signed [mvna_pkg::EDGE_W-1:0]  e1_next [3];
    logic signed [mvna_pkg::EDGE_W-1:0]  e2_reg [3];
    logic signed [mvna_pkg::EDGE_W-1:0]  e2_next [3];
    logic signed [mvna_pkg::CROSS_W-1:0] vec_reg [3];
    logic signed [mvna_pkg::CROSS_W-1:0] vec_next [3];
    logic          out_valid_reg, out_valid_next;
    mvna_pkg::out_word_t out_reg, out_next;

    logic                    vwe, swe;
    logic [mvna_pkg::ADDR_W-1:0] vra, sra, swa, idx_sel;
    logic [SW-1:0]           swd;
    logic signed [mvna_pkg::EDGE_W-1:0] op_a, op_b;
    logic signed [mvna_pkg::PROD_W-1:0] prod;

    function automatic logic [UW-1:0] sat_add(input logic [UW-1:0] s,
                                              input logic [mvna_pkg::NORM_W-1:0] q);
        logic [UW:0] r;
        r = {s[UW-1], s} + (UW+1)'($signed(q));
        if (r[UW] != r[UW-1]) begin
            sat_add = r[UW] ? {1'b1, {(UW-1){1'b0}}} : {1'b0, {(UW-1){1'b1}}};
        end else begin
            sat_add = r[UW-1:0];
        end
    endfunction

    always_comb begin
        case (cnt_reg)
            2'd0:    idx_sel = head.idx0;
            2'd1:    idx_sel = head.idx1;
            default: idx_sel = head.idx2;
        endcase
        case (mcnt_reg)
            3'd0:    begin op_a = e1_reg[1]; op_b = e2_reg[2]; end
            3'd1:    begin op_a = e1_reg[2]; op_b = e2_reg[1]; end
            3'd2:    begin op_a = e1_reg[2]; op_b = e2_reg[0]; end
            3'd3:    begin op_a = e1_reg[0]; op_b = e2_reg[2]; end
            3'd4:    begin op_a = e1_reg[0]; op_b = e2_reg[1]; end
            default: begin op_a = e1_reg[1]; op_b = e2_reg[0]; end
        endcase
        prod = op_a * op_b;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mcnt_next      = mcnt_reg;
        vtx_next       = vtx_reg;
        e1_next        = e1_reg;
        e2_next        = e2_reg;
        vec_next       = vec_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        pop            = 1'b0;
        vwe            = 1'b0;
        swe            = 1'b0;
        vra            = idx_sel;
        sra            = idx_sel;
        swa            = idx_sel;
        swd            = '0;
        nreq.start     = 1'b0;
        nreq.flip      = head.kind == mvna_pkg::K_TRI;
        nreq.vx        = vec_reg[0];
        nreq.vy        = vec_reg[1];
        nreq.vz        = vec_reg[2];
        case (state_reg)
            mvna_pkg::B_IDLE: begin
                cnt_next = '0;
                if (head_valid) begin
                    case (head.kind)
                        mvna_pkg::K_LOAD: begin
                            vwe = 1'b1;
                            swe = 1'b1;
                            swa = head.idx0;
                            pop = 1'b1;
                        end
                        mvna_pkg::K_TRI: begin
                            state_next = mvna_pkg::B_VREAD;
                        end
                        default: begin
                            state_next = head.oor ? mvna_pkg::B_OUT : mvna_pkg::B_SREAD;
                        end
                    endcase
                end
            end
            mvna_pkg::B_VREAD: begin
                // read data is registered, so it arrives in the cycle after its address
                if (cnt_reg != 2'd0) begin
                    vtx_next[cnt_reg - 2'd1] = vrd_reg;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd3) begin
                    state_next = mvna_pkg::B_EDGE;
                end
            end
            mvna_pkg::B_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    e1_next[i] = {vtx_reg[1][CW*(3-i)-1], vtx_reg[1][CW*(3-i)-1 -: CW]}
                               - {vtx_reg[0][CW*(3-i)-1], vtx_reg[0][CW*(3-i)-1 -: CW]};
                    e2_next[i] = {vtx_reg[2][CW*(3-i)-1], vtx_reg[2][CW*(3-i)-1 -: CW]}
                               - {vtx_reg[0][CW*(3-i)-1], vtx_reg[0][CW*(3-i)-1 -: CW]};
                end
                mcnt_next  = '0;
                state_next = mvna_pkg::B_MUL;
            end
            mvna_pkg::B_MUL: begin
                // even steps load the first product, odd steps subtract the second
                if (!mcnt_reg[0]) begin
                    vec_next[mcnt_reg[2:1]] = mvna_pkg::CROSS_W'(prod);
                end else begin
                    vec_next[mcnt_reg[2:1]] = vec_reg[mcnt_reg[2:1]]
                                            - mvna_pkg::CROSS_W'(prod);
                end
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 3'd5) begin
                    state_next = mvna_pkg::B_NSTART;
                end
            end
            mvna_pkg::B_NSTART: begin
                nreq.start = 1'b1;
                state_next = mvna_pkg::B_NWAIT;
            end
            mvna_pkg::B_NWAIT: begin
                if (nrsp.done) begin
                    cnt_next = '0;
                    if (head.kind != mvna_pkg::K_TRI) begin
                        state_next = mvna_pkg::B_OUT;
                    end else if (nrsp.zero) begin
                        pop        = 1'b1;
                        state_next = mvna_pkg::B_IDLE;
                    end else begin
                        state_next = mvna_pkg::B_RMW_RD;
                    end
                end
            end
            mvna_pkg::B_RMW_RD: begin
                state_next = mvna_pkg::B_RMW_UPD;
            end
            mvna_pkg::B_RMW_UPD: begin
                // write lands before the next corner's read, so repeats stack
                swe = 1'b1;
                swd = {sat_add(srd_reg[3*UW-1 -: UW], nrsp.qx),
                       sat_add(srd_reg[2*UW-1 -: UW], nrsp.qy),
                       sat_add(srd_reg[UW-1:0], nrsp.qz)};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd2) begin
                    pop        = 1'b1;
                    state_next = mvna_pkg::B_IDLE;
                end else begin
                    state_next = mvna_pkg::B_RMW_RD;
                end
            end
            mvna_pkg::B_SREAD: begin
                state_next = mvna_pkg::B_SWAIT;
            end
            mvna_pkg::B_SWAIT: begin
                vec_next[0] = mvna_pkg::CROSS_W'($signed(srd_reg[3*UW-1 -: UW]));
                vec_next[1] = mvna_pkg::CROSS_W'($signed(srd_reg[2*UW-1 -: UW]));
                vec_next[2] = mvna_pkg::CROSS_W'($signed(srd_reg[UW-1:0]));
                state_next  = mvna_pkg::B_NSTART;
            end
            mvna_pkg::B_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    if (head.oor) begin
                        out_next.normal_x = '0;
                        out_next.normal_y = '0;
                        out_next.normal_z = '0;
                        out_next.status   = 1'b1;
                    end else begin
                        out_next.normal_x = nrsp.qx;
                        out_next.normal_y = nrsp.qy;
                        out_next.normal_z = nrsp.qz;
                        out_next.status   = nrsp.zero;
                    end
                    out_valid_next = 1'b1;
                    pop            = 1'b1;
                    state_next     = mvna_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = mvna_pkg::B_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (vwe) begin
            vmem[head.idx0] <= head.vtx;
        end
        vrd_reg <= vmem[vra];
    end

    always_ff @(posedge aclk) begin
        if (swe) begin
            smem[swa] <= swd;
        end
        srd_reg <= smem[sra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mvna_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        mcnt_reg <= mcnt_next;
        vtx_reg  <= vtx_next;
        e1_reg   <= e1_next;
        e2_reg   <= e2_next;
        vec_reg  <= vec_next;
        out_reg  <= out_next;
    end

endmodule

[rtl/mesh_vertex_normal_accumulator_top.sv]
// top level of the mesh vertex normal accumulator
// usage:
//   s_ channel takes one command word: load vertex, add triangle or read normal.
//   m_ channel returns one word per read: unit normal in Q1.14 plus status.
//   cfg_ channel writes index_base (offset added to triangle corners); write
//   it only while no command is in flight.
// processing:
//   a load is written and popped in the back end's idle state; a triangle
//   and a read both go through the shared normalising unit: a 32-step
//   bit-serial square root and three restoring divides, plus up to 12
//   prescale shifts for large cross products.
//   triangle corner updates are read-modify-write on a sum memory with one read and one write port.
//   a four-word command queue takes new words while the back end works.
// reset:
//   clears control state and index_base; memories are not cleared, so a vertex
//   must be loaded before it is used or read.
// stall:
//   the result waits in an output register; the back end only halts when a
//   second result is ready and that register is still full, and the queue
//   then fills and drops s_ready.
module mesh_vertex_normal_accumulator_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  mvna_pkg::in_word_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output mvna_pkg::out_word_t         m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mvna_pkg::BASE_W-1:0] cfg_data
);

    logic                pop;
    logic                head_valid;
    mvna_pkg::cmd_t      head;
    mvna_pkg::norm_req_t nreq;
    mvna_pkg::norm_rsp_t nrsp;

    mvna_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mvna_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (nreq),
        .rsp     (nrsp)
    );

    mvna_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .nreq       (nreq),
        .nrsp       (nrsp),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    a_pop_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue popped while empty");

    a_zero_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |->
            m_data.normal_x == '0 && m_data.normal_y == '0 && m_data.normal_z == '0)
        else $error("zero-length status with non-zero normal");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            m_data.normal_x >= -16'sd16384 && m_data.normal_x <= 16'sd16384 &&
            m_data.normal_y >= -16'sd16384 && m_data.normal_y <= 16'sd16384 &&
            m_data.normal_z >= -16'sd16384 && m_data.normal_z <= 16'sd16384)
        else $error("normal component outside unit range");

    a_start_done: assert property (@(posedge aclk) disable iff (!aresetn)
        nreq.start |-> !nrsp.done)
        else $error("normaliser started while finishing");

endmodule

[bench/testbench.sv]
// self-checking bench for the mesh vertex normal accumulator: predicted normals against results
module testbench;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    mvna_pkg::in_word_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    mvna_pkg::out_word_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [mvna_pkg::BASE_W-1:0] cfg_data = '0;

    mesh_vertex_normal_accumulator_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    // predictor state
    logic signed [mvna_pkg::COORD_W-1:0] vert_p [mvna_pkg::MAX_VERTICES][3];
    logic signed [mvna_pkg::SUM_W-1:0]   sum_p  [mvna_pkg::MAX_VERTICES][3];
    bit                                  loaded [mvna_pkg::MAX_VERTICES];
    logic [mvna_pkg::BASE_W-1:0]         base_p = '0;
    mvna_pkg::out_word_t                 normal_q [$];

    int send_idle = 0;
    int recv_stall = 0;
    bit hold_req = 1'b0;
    bit hold_on = 1'b0;
    int mismatches = 0;
    int words_sent = 0;
    int reads_checked = 0;
    int tri_sent = 0;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // unit vector in q1.14; returns 0 on a zero vector
    function automatic bit unit_vec(input longint v [3], input bit flip,
                                    output logic signed [mvna_pkg::NORM_W-1:0] q [3]);
        longint unsigned m [3];
        longint unsigned top, sq, len, r;
        int s;
        top = 0;
        sq = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > top) top = m[i];
            q[i] = '0;
        end
        if (top == 0) return 1'b0;
        while ((top >> s) >= (64'd1 << 31)) s++;
        for (int i = 0; i < 3; i++) begin
            m[i] >>= s;
            sq += m[i] * m[i];
        end
        len = root_floor(sq);
        for (int i = 0; i < 3; i++) begin
            r = (m[i] * 16384 + len / 2) / len;
            q[i] = mvna_pkg::NORM_W'(((v[i] < 0) != flip) ? -r : r);
        end
        return 1'b1;
    endfunction

    function automatic logic signed [mvna_pkg::SUM_W-1:0] sat_sum(longint a);
        if (a > 8388607) return mvna_pkg::SUM_W'(8388607);
        if (a < -8388608) return mvna_pkg::SUM_W'(-8388608);
        return mvna_pkg::SUM_W'(a);
    endfunction

    task automatic predict_word(mvna_pkg::in_word_t w);
        longint v [3], e1 [3], e2 [3];
        logic signed [mvna_pkg::NORM_W-1:0] q [3];
        int idx [3];
        mvna_pkg::out_word_t o;
        case (w.operation)
            mvna_pkg::OP_LOAD: begin
                longint nx;
                nx = -longint'(w.coord_x);
                if (nx > 524287) nx = 524287;
                vert_p[w.index_a][0] = mvna_pkg::COORD_W'(nx);
                vert_p[w.index_a][1] = w.coord_z;
                vert_p[w.index_a][2] = w.coord_y;
                for (int i = 0; i < 3; i++) sum_p[w.index_a][i] = '0;
                loaded[w.index_a] = 1'b1;
            end
            mvna_pkg::OP_TRI: begin
                idx[0] = int'(w.index_a) + int'(base_p);
                idx[1] = int'(w.index_b) + int'(base_p);
                idx[2] = int'(w.index_c) + int'(base_p);
                if (idx[0] < mvna_pkg::MAX_VERTICES && idx[1] < mvna_pkg::MAX_VERTICES
                        && idx[2] < mvna_pkg::MAX_VERTICES) begin
                    for (int i = 0; i < 3; i++) begin
                        e1[i] = longint'(vert_p[idx[1]][i]) - vert_p[idx[0]][i];
                        e2[i] = longint'(vert_p[idx[2]][i]) - vert_p[idx[0]][i];
                    end
                    v[0] = e1[1] * e2[2] - e1[2] * e2[1];
                    v[1] = e1[2] * e2[0] - e1[0] * e2[2];
                    v[2] = e1[0] * e2[1] - e1[1] * e2[0];
                    if (unit_vec(v, 1'b1, q))
                        for (int k = 0; k < 3; k++)
                            for (int i = 0; i < 3; i++)
                                sum_p[idx[k]][i] =
                                    sat_sum(longint'(sum_p[idx[k]][i]) + q[i]);
                end
            end
            mvna_pkg::OP_READ: begin
                for (int i = 0; i < 3; i++) v[i] = sum_p[w.index_a][i];
                o.status = ~unit_vec(v, 1'b0, q);
                o.normal_x = q[0];
                o.normal_y = q[1];
                o.normal_z = q[2];
                normal_q = {normal_q, o};
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (normal_q.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                mvna_pkg::out_word_t e;
                e = normal_q.pop_front();
                reads_checked++;
                if (m_data.normal_x !== e.normal_x)
                    report_mismatch("normal_x", m_data.normal_x, e.normal_x);
                if (m_data.normal_y !== e.normal_y)
                    report_mismatch("normal_y", m_data.normal_y, e.normal_y);
                if (m_data.normal_z !== e.normal_z)
                    report_mismatch("normal_z", m_data.normal_z, e.normal_z);
                if (m_data.status !== e.status)
                    report_mismatch("status", m_data.status, e.status);
            end
        end
    end

    // long receiver hold-off, counted here once requested
    initial begin : hold_off
        wait (hold_req);
        hold_on <= 1'b1;
        repeat (3000) @(negedge aclk);
        hold_on <= 1'b0;
    end

    // receiver: random stalls plus the long hold-off
    always @(negedge aclk) begin
        m_ready <= hold_on ? 1'b0 : ($urandom_range(99) >= recv_stall);
    end

    task automatic send_word(mvna_pkg::in_word_t w);
        int idle;
        idle = 0;
        while ($urandom_range(99) < send_idle) idle++;
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_word(w);
        words_sent++;
        if (w.operation == mvna_pkg::OP_TRI) tri_sent++;
        @(negedge aclk);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (normal_q.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        // triangles may still be queued with nothing expected
        repeat (1000) @(negedge aclk);
    endtask

    task automatic write_base(logic [mvna_pkg::BASE_W-1:0] b);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= b;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        base_p = b;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic mvna_pkg::in_word_t load_word(int i, int x, int y, int z);
        mvna_pkg::in_word_t w;
        w = '0;
        w.operation = mvna_pkg::OP_LOAD;
        w.index_a = mvna_pkg::IDX_W'(i);
        w.index_b = mvna_pkg::IDX_W'($urandom);
        w.index_c = mvna_pkg::IDX_W'($urandom);
        w.coord_x = mvna_pkg::COORD_W'(x);
        w.coord_y = mvna_pkg::COORD_W'(y);
        w.coord_z = mvna_pkg::COORD_W'(z);
        return w;
    endfunction

    function automatic mvna_pkg::in_word_t op_word(logic [1:0] op, int a, int b, int c);
        mvna_pkg::in_word_t w;
        w = '0;
        w.operation = op;
        w.index_a = mvna_pkg::IDX_W'(a);
        w.index_b = mvna_pkg::IDX_W'(b);
        w.index_c = mvna_pkg::IDX_W'(c);
        w.coord_x = mvna_pkg::COORD_W'($urandom);
        w.coord_y = mvna_pkg::COORD_W'($urandom);
        w.coord_z = mvna_pkg::COORD_W'($urandom);
        return w;
    endfunction

    task automatic test_directed;
        send_word(load_word(0, 0, 0, 0));
        send_word(load_word(1, 256, 0, 0));
        send_word(load_word(2, 0, 256, 0));
        send_word(load_word(4095, -524288, 524287, -524288));
        send_word(load_word(4094, 524287, -524288, 524287));
        send_word(load_word(4093, 0, -524288, 524287));
        send_word(load_word(3, 0, 0, 0));
        send_word(op_word(mvna_pkg::OP_TRI, 0, 1, 2));
        send_word(op_word(mvna_pkg::OP_TRI, 0, 0, 1));      // repeated corners
        send_word(op_word(mvna_pkg::OP_TRI, 0, 3, 1));      // degenerate face
        send_word(op_word(mvna_pkg::OP_TRI, 4095, 4094, 4093));
        send_word(op_word(mvna_pkg::OP_READ, 0, 0, 0));
        send_word(op_word(mvna_pkg::OP_READ, 1, 0, 0));
        send_word(op_word(mvna_pkg::OP_READ, 3, 0, 0));     // zero sum
        send_word(op_word(mvna_pkg::OP_READ, 4095, 0, 0));
        send_word(op_word(2'd3, 0, 0, 0));                  // unused operation
        // saturate a sum by repeating one face
        for (int i = 0; i < 520; i++) send_word(op_word(mvna_pkg::OP_TRI, 0, 1, 2));
        send_word(op_word(mvna_pkg::OP_READ, 2, 0, 0));
    endtask

    task automatic test_base_offset;
        write_base(12'd4094);
        send_word(op_word(mvna_pkg::OP_TRI, 0, 1, 2));      // out of range, dropped
        send_word(op_word(mvna_pkg::OP_TRI, 1, 0, 1));
        send_word(op_word(mvna_pkg::OP_READ, 4095, 0, 0));
        write_base(12'd4095);
        send_word(op_word(mvna_pkg::OP_TRI, 0, 0, 0));
        send_word(op_word(mvna_pkg::OP_READ, 4095, 0, 0));
        write_base(12'd0);
    endtask

    // mostly well-formed meshes on a small vertex window
    task automatic random_burst(int count);
        mvna_pkg::in_word_t w;
        int lo, pick;
        lo = $urandom_range(4000);
        for (int i = 0; i < 100; i++)
            if (!loaded[i]) send_word(load_word(i, 0, 0, 0));
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                w = load_word($urandom_range(1) ? $urandom_range(63) : lo + $urandom_range(63),
                              $urandom_range(3) == 0 ? $urandom : $urandom_range(8191) - 4096,
                              $urandom_range(3) == 0 ? $urandom : $urandom_range(8191) - 4096,
                              $urandom_range(3) == 0 ? $urandom : $urandom_range(8191) - 4096);
            end else if (pick < 60) begin
                w = op_word(mvna_pkg::OP_TRI, $urandom_range(63), $urandom_range(63),
                            $urandom_range(63));
                if ($urandom_range(15) == 0) w.index_c = mvna_pkg::IDX_W'($urandom);
                if (int'(w.index_c) + int'(base_p) < mvna_pkg::MAX_VERTICES
                        && !loaded[int'(w.index_c) + int'(base_p)])
                    w.index_c = '0;
            end else if (pick < 95) begin
                w = op_word(mvna_pkg::OP_READ, $urandom_range(63), $urandom, $urandom);
                if ($urandom_range(15) == 0) w.index_a = mvna_pkg::IDX_W'($urandom);
                if (!loaded[w.index_a]) w.index_a = '0;
            end else begin
                w = op_word(2'd3, $urandom, $urandom, $urandom);
            end
            if (w.operation == mvna_pkg::OP_TRI)
                for (int k = 0; k < 3; k++) begin
                    int ix;
                    ix = int'(k == 0 ? w.index_a : k == 1 ? w.index_b : w.index_c)
                         + int'(base_p);
                    if (ix < mvna_pkg::MAX_VERTICES && !loaded[ix])
                        w.operation = mvna_pkg::OP_READ;
                end
            if (w.operation == mvna_pkg::OP_READ && !loaded[w.index_a]) w.index_a = '0;
            send_word(w);
        end
    endtask

    task automatic test_random;
        send_idle = 0;  recv_stall = 0;  random_burst(150);
        send_idle = 59; recv_stall = 0;  random_burst(150);
        send_idle = 0;  recv_stall = 59; random_burst(150);
        write_base(12'd7);
        send_idle = 27; recv_stall = 27; random_burst(150);
        write_base(12'd0);
        send_idle = 0;  recv_stall = 0;  random_burst(150);
    endtask

    task automatic test_backpressure;
        send_idle = 0;
        recv_stall = 0;
        drain();
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) send_word(op_word(mvna_pkg::OP_READ, i % 4, 0, 0));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_base_offset();
        test_random();
        test_backpressure();
        drain();
        $display("%0d words sent, %0d triangles, %0d normals checked over four index bases",
                 words_sent, tri_sent, reads_checked);
        if (mismatches == 0 && normal_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
